// ----- sv/pemidi_pkg.sv -----
`default_nettype none

package pemidi_pkg;

    typedef enum logic [1:0] {
        CMD_BUTTON = 2'd0,
        CMD_JOG    = 2'd1,
        CMD_BROWSE = 2'd2,
        CMD_PITCH  = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    localparam int CNT_W        = 5;
    localparam int IDX_W        = 4;
    localparam int BUTTON_COUNT = 14;

    localparam logic [7:0] ST_NOTE_ON_CH1    = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF_CH1   = 8'h80;
    localparam logic [7:0] ST_CC_CH1         = 8'hB0;
    localparam logic [7:0] ST_CC_CH2         = 8'hB1;
    localparam logic [7:0] ST_NOTE_ON_CH3    = 8'h92;
    localparam logic [7:0] ST_NOTE_OFF_CH3   = 8'h82;

    localparam logic [6:0] VEL_FULL     = 7'd127;
    localparam logic [6:0] VEL_ZERO     = 7'd0;
    localparam logic [6:0] JOG_UP       = 7'd65;
    localparam logic [6:0] JOG_DOWN     = 7'd63;
    localparam logic [6:0] BROWSE_UP    = 7'd70;
    localparam logic [6:0] BROWSE_DOWN  = 7'd71;
    localparam logic [6:0] CC_JOG       = 7'd20;
    localparam logic [6:0] CC_PITCH_MSB = 7'd0;
    localparam logic [6:0] CC_PITCH_LSB = 7'd32;

    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
    } dp_stat_t;

    function automatic logic [6:0] button_note(input logic [3:0] idx);
        logic [6:0] note;
        case (idx)
            4'd0:    note = 7'd63;
            4'd1:    note = 7'd64;
            4'd2:    note = 7'd65;
            4'd3:    note = 7'd66;
            4'd4:    note = 7'd67;
            4'd5:    note = 7'd61;
            4'd6:    note = 7'd60;
            4'd7:    note = 7'd68;
            4'd8:    note = 7'd69;
            4'd9:    note = 7'd70;
            4'd10:   note = 7'd71;
            4'd11:   note = 7'd72;
            4'd12:   note = 7'd62;
            4'd13:   note = 7'd73;
            default: note = 7'd0;
        endcase
        return note;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pemidi_ctrl.sv -----
`default_nettype none

module pemidi_ctrl
    import pemidi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     evt_valid,
    output logic          evt_ready,
    output logic          msg_valid,
    input  wire logic     msg_ready,
    output dp_cmd_t       dp_cmd,
    input  wire dp_stat_t dp_stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid && !dp_stat.empty)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (msg_ready && dp_stat.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        evt_ready      = 1'b0;
        msg_valid      = 1'b0;
        dp_cmd.load    = 1'b0;
        dp_cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                evt_ready   = 1'b1;
                dp_cmd.load = evt_valid;
            end
            ST_EMIT:
            begin
                msg_valid      = 1'b1;
                dp_cmd.advance = msg_ready;
            end
            default:
            begin
                evt_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/pemidi_dp.sv -----
`default_nettype none

module pemidi_dp
    import pemidi_pkg::*;
#(
    parameter int MAX_BURST = 8
)
(
    input  wire logic        clk,
    input  wire dp_cmd_t     dp_cmd,
    output dp_stat_t         dp_stat,
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  button_index,
    input  wire logic signed [15:0] event_value,
    output logic [7:0]       status_byte,
    output logic [6:0]       data_one,
    output logic [6:0]       data_two,
    output logic             last_message
);

    cmd_t             cmd_reg;
    logic [6:0]       note_reg;
    logic             pos_reg;
    logic             pressed_reg;
    logic [13:0]      pitch_reg;
    logic [CNT_W-1:0] total_reg;
    logic [IDX_W-1:0] idx_reg;

    logic [15:0]      mag;
    logic [IDX_W-1:0] ticks;
    logic [CNT_W-1:0] total_next;
    logic             positive;
    logic [6:0]       browse_note;

    always_comb
    begin
        mag      = event_value[15] ? (~event_value + 16'd1) : event_value;
        ticks    = (mag > 16'(MAX_BURST)) ? IDX_W'(MAX_BURST) : mag[IDX_W-1:0];
        positive = (event_value != 16'sd0) && !event_value[15];
        case (cmd_t'(cmd))
            CMD_BUTTON: total_next = (button_index < 4'(BUTTON_COUNT)) ? CNT_W'(1) : '0;
            CMD_JOG:    total_next = {1'b0, ticks};
            CMD_BROWSE: total_next = {ticks, 1'b0};
            CMD_PITCH:  total_next = CNT_W'(2);
            default:    total_next = '0;
        endcase
    end

    assign dp_stat.empty = (total_next == '0);
    assign dp_stat.last  = ({1'b0, idx_reg} == (total_reg - CNT_W'(1)));

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg     <= cmd_t'(cmd);
            note_reg    <= button_note(button_index);
            pos_reg     <= positive;
            pressed_reg <= (event_value != 16'sd0);
            pitch_reg   <= event_value[13:0];
            total_reg   <= total_next;
            idx_reg     <= '0;
        end
        else if (dp_cmd.advance)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    assign browse_note = pos_reg ? BROWSE_UP : BROWSE_DOWN;

    always_comb
    begin
        case (cmd_reg)
            CMD_BUTTON:
            begin
                status_byte = pressed_reg ? ST_NOTE_ON_CH1 : ST_NOTE_OFF_CH1;
                data_one    = note_reg;
                data_two    = pressed_reg ? VEL_FULL : VEL_ZERO;
            end
            CMD_JOG:
            begin
                status_byte = ST_CC_CH2;
                data_one    = CC_JOG;
                data_two    = pos_reg ? JOG_UP : JOG_DOWN;
            end
            CMD_BROWSE:
            begin
                status_byte = idx_reg[0] ? ST_NOTE_OFF_CH3 : ST_NOTE_ON_CH3;
                data_one    = browse_note;
                data_two    = idx_reg[0] ? VEL_ZERO : VEL_FULL;
            end
            CMD_PITCH:
            begin
                status_byte = ST_CC_CH1;
                data_one    = idx_reg[0] ? CC_PITCH_LSB : CC_PITCH_MSB;
                data_two    = idx_reg[0] ? pitch_reg[6:0] : pitch_reg[13:7];
            end
            default:
            begin
                status_byte = ST_CC_CH1;
                data_one    = VEL_ZERO;
                data_two    = VEL_ZERO;
            end
        endcase
        last_message = dp_stat.last;
    end

endmodule

`default_nettype wire

// ----- sv/panel_event_to_midi_encoder.sv -----
// Panel event to MIDI encoder.
// The event channel (evt_valid, evt_ready, cmd, button_index, event_value) takes one
// control-panel event; the message channel (msg_valid, msg_ready, status_byte,
// data_one, data_two, last_message) returns its run of three-byte MIDI messages.
// An event is taken only while the block is idle. The first message is offered
// in the cycle after the event is accepted and each further message in the cycle
// after the previous one is taken; a browse burst of MAX_BURST ticks gives twice
// MAX_BURST messages. The message counter in the datapath, stepped once per
// delivered message, marks the end of the run.
// An event that gives no messages (a button index of 14 or more, or zero ticks)
// is consumed in its accept cycle and the block is ready again at once.
// last_message marks the final message of each run.
// When the receiver holds msg_ready low the current message is held unchanged and
// no new event is accepted until the run has been delivered.
// Reset returns the controller to idle and drops msg_valid; no run survives it.
`default_nettype none

module panel_event_to_midi_encoder
    import pemidi_pkg::*;
#(
    parameter int MAX_BURST = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        evt_valid,
    output logic             evt_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  button_index,
    input  wire logic signed [15:0] event_value,
    output logic             msg_valid,
    input  wire logic        msg_ready,
    output logic [7:0]       status_byte,
    output logic [6:0]       data_one,
    output logic [6:0]       data_two,
    output logic             last_message
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    pemidi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    pemidi_dp #(
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .clk          (clk),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .cmd          (cmd),
        .button_index (button_index),
        .event_value  (event_value),
        .status_byte  (status_byte),
        .data_one     (data_one),
        .data_two     (data_two),
        .last_message (last_message)
    );

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready) |-> !msg_valid)
        else $error("event accepted while a run is in progress");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_ready && last_message) |=> !msg_valid)
        else $error("message offered after the final one of a run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_ready && !last_message) |=> msg_valid)
        else $error("run ended without a final message");

    a_status_bit: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid |-> status_byte[7])
        else $error("status byte without its top bit");

endmodule

`default_nettype wire
